// ===== rtl/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and constants of the subset-sum way counter
// Table geometry, field widths, sequencer states and RAM port bundles.
// ----------------------------------------------------------------------------
package ssw_pkg;

	// largest partial sum kept in the count table
	localparam int MAX_SUM = 1024;
	localparam int DEPTH   = MAX_SUM + 1;
	localparam int ADDR_W  = $clog2(DEPTH);

	localparam int VAL_W   = 11;
	localparam int CNT_W   = 32;
	localparam int TDATA_W = ((VAL_W + 7) / 8) * 8;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE,
		ST_DRAIN,
		ST_READ,
		ST_REPORT
	} state_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CNT_W-1:0]  data;
	} ram_wr_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} ram_rd_t;

endpackage

// ===== rtl/ssw_count_ram.sv =====
// ----------------------------------------------------------------------------
// ssw_count_ram: count table storage
// One write port, two registered read ports; read data holds when idle.
// ----------------------------------------------------------------------------
module ssw_count_ram
	import ssw_pkg::*;
(
	input  logic             clk,
	input  ram_wr_t          wr,
	input  ram_rd_t          rd,
	output logic [CNT_W-1:0] rd_data_a,
	output logic [CNT_W-1:0] rd_data_b
);

	logic [CNT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_a <= mem[rd.addr_a];
			rd_data_b <= mem[rd.addr_b];
		end
	end

endmodule

// ===== rtl/subset_sum_way_counter.sv =====
// ----------------------------------------------------------------------------
// subset_sum_way_counter: counts subsets of a value stream that hit a target
// Table-driven 0/1 subset counting with a single shared saturating 32-bit adder.
// ----------------------------------------------------------------------------
// Usage: write target_sum on the cfg channel while idle, then stream values on
// s_axis, marking the final value of a set with tlast. Each value v <= 1024
// walks table entries s = 1024 down to v, one read-modify-write per cycle
// through a single saturating adder: count[s] += count[s - v]. A value
// occupies the input through accept, walk and a write-back step; a value
// above 1024 changes nothing. After the tlast value is done, the count at
// target_sum (0 if the target exceeds 1024) is read in the read state and
// then, in the report state, placed with the saturation flag in the output
// register; that load waits while an earlier result is still untaken. Then
// the table is swept back to one at zero and zero elsewhere, during which
// s_axis is not ready. The same sweep runs after reset. The pace is set by
// the table RAM: one write port, so one entry per cycle. A finished result
// may sit in the output register while the next set is already streaming.
// ----------------------------------------------------------------------------
module subset_sum_way_counter
	import ssw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	// configuration: target_sum
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [VAL_W-1:0]   cfg_data,

	// input stream
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // [10:0] item_value, rest zero
	input  logic               s_axis_tlast,   // last_item

	// result stream
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [CNT_W-1:0]   m_axis_tdata,   // [31:0] way_count
	output logic               m_axis_tuser    // [0] count_saturated
);

	state_t state_q, state_nxt;

	logic [VAL_W-1:0]  target_q;
	logic [VAL_W-1:0]  val_q;
	logic              last_q;
	logic [ADDR_W-1:0] s_q;        // walk index (high sums first)
	logic [ADDR_W-1:0] clr_q;      // clear sweep index
	logic              sat_q;      // saturation seen in this set

	// write-back stage of the read-modify-write
	logic              valid_s1;
	logic [ADDR_W-1:0] waddr_s1;

	logic              m_valid_q;
	logic [CNT_W-1:0]  m_data_q;
	logic              m_user_q;

	ram_wr_t           ram_wr;
	ram_rd_t           ram_rd;
	logic [CNT_W-1:0]  rd_a, rd_b;

	logic [VAL_W-1:0]  in_val;
	logic              in_xfer;
	logic              in_range;
	logic              tgt_ok;
	logic [CNT_W:0]    sum;
	logic              load_out;
	logic              walk_done;

	assign in_val    = s_axis_tdata[VAL_W-1:0];
	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign in_range  = (in_val <= VAL_W'(MAX_SUM));
	assign tgt_ok    = (target_q <= VAL_W'(MAX_SUM));
	assign walk_done = (s_q == ADDR_W'(val_q));
	assign load_out  = (state_q == ST_REPORT) && (!m_valid_q || m_axis_tready);

	// shared saturating adder
	assign sum = {1'b0, rd_a} + {1'b0, rd_b};

	assign cfg_ready = 1'b1;

	ssw_count_ram u_ram (
		.clk       (clk),
		.wr        (ram_wr),
		.rd        (ram_rd),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_q == '0) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_xfer) begin
					if (in_range)          state_nxt = ST_UPDATE;
					else if (s_axis_tlast) state_nxt = ST_READ;
				end
			end
			ST_UPDATE: begin
				if (walk_done) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_nxt = last_q ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_nxt = ST_REPORT;
			end
			ST_REPORT: begin
				if (load_out) state_nxt = ST_CLEAR;
			end
			default: state_nxt = ST_CLEAR;
		endcase
	end

	// sequencer outputs: RAM ports and input ready
	always_comb begin
		s_axis_tready = 1'b0;
		ram_rd        = '0;
		ram_wr.en     = valid_s1;
		ram_wr.addr   = waddr_s1;
		ram_wr.data   = sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
		unique case (state_q) inside
			ST_CLEAR: begin
				ram_wr.en   = 1'b1;
				ram_wr.addr = clr_q;
				ram_wr.data = (clr_q == '0) ? CNT_W'(1) : '0;
			end
			ST_IDLE: begin
				s_axis_tready = 1'b1;
			end
			ST_UPDATE: begin
				ram_rd.en     = 1'b1;
				ram_rd.addr_a = s_q;
				ram_rd.addr_b = s_q - ADDR_W'(val_q);
			end
			ST_READ: begin
				ram_rd.en     = 1'b1;
				ram_rd.addr_a = tgt_ok ? ADDR_W'(target_q) : '0;
			end
			ST_DRAIN, ST_REPORT: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_q     <= ADDR_W'(MAX_SUM);
			target_q  <= '0;
			sat_q     <= 1'b0;
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			valid_s1 <= (state_q == ST_UPDATE);

			if (cfg_valid && cfg_ready) target_q <= cfg_data;

			if (state_q == ST_CLEAR)  clr_q <= clr_q - ADDR_W'(1);
			else if (load_out)        clr_q <= ADDR_W'(MAX_SUM);

			if (load_out)                  sat_q <= 1'b0;
			else if (valid_s1 && sum[CNT_W]) sat_q <= 1'b1;

			if (load_out)                             m_valid_q <= 1'b1;
			else if (m_axis_tready)                   m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		waddr_s1 <= s_q;
		if (in_xfer) begin
			val_q  <= in_val;
			last_q <= s_axis_tlast;
			s_q    <= ADDR_W'(MAX_SUM);
		end else if (state_q == ST_UPDATE) begin
			s_q <= s_q - ADDR_W'(1);
		end
		if (load_out) begin
			m_data_q <= tgt_ok ? rd_a : '0;
			m_user_q <= sat_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

	// write-back only follows a walk read
	a_wb_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (state_q == ST_UPDATE || state_q == ST_DRAIN))
		else $error("write-back outside table walk");

	// no new item while a write-back is in flight
	a_ready_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !valid_s1)
		else $error("input ready during write-back");

	// walk index never drops below the value
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (s_q >= ADDR_W'(val_q)))
		else $error("walk index below value");

	// a result appears only from the report state
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> ($past(state_q) == ST_REPORT))
		else $error("result loaded outside report");

	// the clear sweep always ends in idle
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && clr_q == '0) |=> (state_q == ST_IDLE))
		else $error("clear sweep did not end in idle");

endmodule
